// ===== rtl/ubds_pkg.sv =====
// Shared types and constants for the UART baud divisor search core.
// No dependencies; every other file imports this package.
package ubds_pkg;

  localparam int SPEED_W = 22;          // clamped rate fits below 2^22
  localparam int DVD1_W = 26;           // 48 MHz fits below 2^26
  localparam int DVD2_W = 30;           // 16 x 48 MHz fits below 2^30
  localparam int Q1_W = 9;              // first quotient stays below 512
  localparam int Q2_W = 26;             // scaled rate quotient
  localparam int DIV_W = 9;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [DVD1_W-1:0] BASE_CLOCK = DVD1_W'(48000000);
  localparam logic [DVD2_W-1:0] SCALED_CLOCK = DVD2_W'(768000000);
  localparam logic [31:0] RATE_LO = 32'd46;
  localparam logic [31:0] RATE_HI = 32'd3000000;
  localparam logic [SPEED_W-1:0] PS1_FLOOR = SPEED_W'(366);
  localparam logic [SPEED_W-1:0] PS2_FLOOR = SPEED_W'(2929);
  localparam logic [SPEED_W-1:0] PS3_FLOOR = SPEED_W'(23437);
  localparam logic [7:0] FLUSH_VERSION = 8'h27;
  localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(9);
  localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(255);
  localparam logic [DIV_W-1:0] DIV_FLOOR = DIV_W'(2);
  localparam logic [DIV_W-1:0] WORD_BASE = DIV_W'(256);

  localparam logic REG_LIMITED = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  typedef struct packed {
    logic               err;
    logic [SPEED_W-1:0] speed;
    logic [1:0]         ps;
  } req_t;

  typedef struct packed {
    logic             err;
    logic [1:0]       ps;
    logic             fact;
    logic [DIV_W-1:0] div;
  } sel_t;

endpackage

// ===== rtl/ubds_front.sv =====
// Front stage: takes a rate word, flags zero, clamps and picks the prescaler.
// Depends on ubds_pkg; feeds ubds_queue.
module ubds_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          requested_rate,
  input  logic                 q_full,
  output logic                 push,
  output ubds_pkg::req_t       req
);
  import ubds_pkg::*;

  logic         f_valid;
  req_t         f_req;
  req_t         cls;
  logic [31:0]  clamped;

  always_comb begin
    if (requested_rate < RATE_LO) begin
      clamped = RATE_LO;
    end else if (requested_rate > RATE_HI) begin
      clamped = RATE_HI;
    end else begin
      clamped = requested_rate;
    end
    cls.err = (requested_rate == 32'd0);
    cls.speed = clamped[SPEED_W-1:0];
    if (cls.speed > PS3_FLOOR) begin
      cls.ps = 2'd3;
    end else if (cls.speed > PS2_FLOOR) begin
      cls.ps = 2'd2;
    end else if (cls.speed > PS1_FLOOR) begin
      cls.ps = 2'd1;
    end else begin
      cls.ps = 2'd0;
    end
  end

  assign push = f_valid && !q_full;
  assign in_ready = !f_valid || !q_full;
  assign req = f_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_req <= cls;
    end
  end

endmodule

// ===== rtl/ubds_queue.sv =====
// Short word queue between the front stage and the divider back end.
// Depends on ubds_pkg.
module ubds_queue #(
  parameter int DEPTH = ubds_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ubds_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ubds_pkg::req_t head_data
);
  import ubds_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count past depth");
`endif

endmodule

// ===== rtl/ubds_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on ubds_pkg only by convention; used by ubds_back.
module ubds_div #(
  parameter int DW = 26,
  parameter int VW = 22,
  parameter int QW = 9,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [TW-1:0] tag_out
);
  import ubds_pkg::*;

  localparam int RW = (DW > VW + QW) ? DW : VW + QW;

  logic [RW-1:0] rem [0:QW-1];
  logic [VW-1:0] dvs [0:QW-1];
  logic [QW-1:0] quo [0:QW];
  logic [TW-1:0] tg  [0:QW];
  logic          vld [0:QW];

  assign rem[0] = RW'(dividend);
  assign dvs[0] = divisor;
  assign quo[0] = '0;
  assign tg[0] = tag_in;
  assign vld[0] = in_valid;

  // Stage k settles quotient bit QW-1-k against the divisor shifted up to it.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] sub;
    logic          fits;

    assign sub = RW'(dvs[k]) << B;
    assign fits = (rem[k] >= sub);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1] <= quo[k] | (QW'(fits) << B);
        tg[k+1] <= tg[k];
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fits ? rem[k] - sub : rem[k];
          dvs[k+1] <= dvs[k];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient = quo[QW];
  assign tag_out = tg[QW];

endmodule

// ===== rtl/ubds_back.sv =====
// Back end: divides down, picks the base clock, rounds and builds the word.
// Depends on ubds_pkg and ubds_div; fed by ubds_queue.
module ubds_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  ubds_pkg::req_t head_data,
  output logic           pop,
  input  logic           limited,
  input  logic           flush,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           rate_error,
  output logic [15:0]    setting_word,
  output logic [1:0]     prescaler_sel,
  output logic           factor_sel,
  output logic [8:0]     divisor_out
);
  import ubds_pkg::*;

  logic en;
  assign en = !out_valid || out_ready;
  assign pop = en && head_valid;

  // First division: base clock over (clock divide x rate) with the full clock.
  logic [3:0]        e1;
  logic [DVD1_W-1:0] dvd1;
  logic              a_valid;
  logic [Q1_W-1:0]   a_quo;
  req_t              a_req;

  assign e1 = 4'(4'd11 - 4'(head_data.ps) * 4'd3);
  assign dvd1 = BASE_CLOCK >> e1;

  ubds_div #(.DW(DVD1_W), .VW(SPEED_W), .QW(Q1_W), .TW($bits(req_t))) u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(head_valid),
    .dividend(dvd1), .divisor(head_data.speed), .tag_in(head_data),
    .out_valid(a_valid), .quotient(a_quo), .tag_out(a_req)
  );

  // Base clock choice, registered before the two rounding divisions.
  logic              halve;
  logic [DIV_W-1:0]  div_sel;
  logic              b_valid;
  sel_t              b_sel;
  logic [SPEED_W-1:0] b_speed;
  logic [DVD2_W-1:0] b_dvd2;
  logic [3:0]        e2;

  assign halve = (a_quo < DIV_MIN) || (a_quo > DIV_MAX) || (a_req.ps != 2'd3 && limited);
  assign div_sel = halve ? (a_quo >> 1) : a_quo;
  assign e2 = 4'(4'd11 - 4'(a_req.ps) * 4'd3) + {3'd0, halve};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sel.err <= a_req.err || (div_sel < DIV_FLOOR);
      b_sel.ps <= a_req.ps;
      b_sel.fact <= !halve;
      b_sel.div <= div_sel;
      b_speed <= a_req.speed;
      b_dvd2 <= SCALED_CLOCK >> e2;
    end
  end

  // Scaled rates at the chosen divisor and at one above it.
  logic              c_valid;
  logic              c3_valid;
  logic [Q2_W-1:0]   q_at;
  logic [Q2_W-1:0]   q_next;
  sel_t              c_sel;
  logic [SPEED_W-1:0] c_speed;

  ubds_div #(.DW(DVD2_W), .VW(DIV_W), .QW(Q2_W), .TW($bits(sel_t))) u_div_at (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .dividend(b_dvd2), .divisor(b_sel.div), .tag_in(b_sel),
    .out_valid(c_valid), .quotient(q_at), .tag_out(c_sel)
  );

  ubds_div #(.DW(DVD2_W), .VW(DIV_W), .QW(Q2_W), .TW(SPEED_W)) u_div_next (
    .clk(clk), .rst(rst), .en(en), .in_valid(b_valid),
    .dividend(b_dvd2), .divisor(b_sel.div + 1'b1), .tag_in(b_speed),
    .out_valid(c3_valid), .quotient(q_next), .tag_out(c_speed)
  );

  logic [31:0]      scaled;
  logic [31:0]      above;
  logic [31:0]      below;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] div_f;
  logic             fact_f;
  logic [7:0]       hi_byte;

  always_comb begin
    scaled = {6'd0, c_speed, 4'd0};
    above = 32'(q_at) - scaled;
    below = scaled - 32'(q_next);
    div_r = c_sel.div + DIV_W'(above >= below);
    // An even divisor on the full clock is the same rate on the halved clock.
    if (c_sel.fact && !div_r[0]) begin
      div_f = div_r >> 1;
      fact_f = 1'b0;
    end else begin
      div_f = div_r;
      fact_f = c_sel.fact;
    end
    hi_byte = 8'(WORD_BASE - div_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rate_error <= c_sel.err;
      if (c_sel.err) begin
        setting_word <= '0;
        prescaler_sel <= '0;
        factor_sel <= 1'b0;
        divisor_out <= '0;
      end else begin
        setting_word <= {hi_byte, flush, 4'd0, fact_f, c_sel.ps};
        prescaler_sel <= c_sel.ps;
        factor_sel <= fact_f;
        divisor_out <= div_f;
      end
    end
  end

`ifndef SYNTHESIS
  a_div_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    c_valid == c3_valid) else $error("rounding dividers out of step");
  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_error |-> setting_word == 16'd0 && divisor_out == 9'd0)
    else $error("error word carries data");
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rate_error |-> divisor_out >= 9'd2 && divisor_out <= 9'd256)
    else $error("divisor out of range");
  a_word_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rate_error |-> setting_word[2] == factor_sel
    && setting_word[1:0] == prescaler_sel) else $error("word fields disagree");
`endif

endmodule

// ===== rtl/uart_baud_divisor_search_core.sv =====
// Top level of the UART baud divisor search core: config registers and wiring.
// Depends on ubds_pkg, ubds_front, ubds_queue and ubds_back.
//
// Turns a requested line rate into a clock setting word for a 48 MHz base
// clock. A zero rate returns rate_error with all other fields zero; any other
// rate is clamped to 46..3000000 bit/s. One word is taken per clock while
// in_ready is high, and one result word is returned per input word, in order.
// A result passes the front register, which loads at acceptance, then the
// queue, a 9-stage divider for the first quotient, one selection stage, a
// 26-stage divider pair for the rounding comparison and the output register.
// Both sides may stall freely; the queue lets the front keep taking words
// while the back is held. Configuration (index 0 limited_prescaler, index 1
// chip_version) is to be written by the user only while no word is in flight;
// the block itself does not enforce it.
module uart_baud_divisor_search_core #(
  parameter int QUEUE_DEPTH = ubds_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] requested_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        rate_error,
  output logic [15:0] setting_word,
  output logic [1:0]  prescaler_sel,
  output logic        factor_sel,
  output logic [8:0]  divisor_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import ubds_pkg::*;

  logic       limited_prescaler;
  logic [7:0] chip_version;

  always_ff @(posedge clk) begin
    if (rst) begin
      limited_prescaler <= 1'b0;
      chip_version <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMITED: limited_prescaler <= cfg_data[0];
        REG_VERSION: chip_version <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_full;
  logic push;
  req_t push_data;
  logic pop;
  logic head_valid;
  req_t head_data;

  ubds_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .requested_rate(requested_rate), .q_full(q_full), .push(push), .req(push_data)
  );

  ubds_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head_data(head_data)
  );

  ubds_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_data(head_data), .pop(pop),
    .limited(limited_prescaler), .flush(chip_version > FLUSH_VERSION),
    .out_valid(out_valid), .out_ready(out_ready), .rate_error(rate_error),
    .setting_word(setting_word), .prescaler_sel(prescaler_sel),
    .factor_sel(factor_sel), .divisor_out(divisor_out)
  );

endmodule
